[hw/rtl/nfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_pkg
// Types and constants shared by the nibble text fork decoder.
// ----------------------------------------------------------------------------
package nfd_pkg;

  localparam int unsigned CHAR_W = 7;

  localparam logic [CHAR_W-1:0] CH_END  = 7'h7C;  // '|'
  localparam logic [CHAR_W-1:0] CH_LOW  = 7'h40;  // '@'
  localparam logic [CHAR_W-1:0] CH_HIGH = 7'h4F;  // 'O'

  localparam logic [2:0] TRAILER_LAST = 3'd7;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        check_ok;
    logic [31:0] byte_total;
    logic [31:0] received_check;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/nfd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_if
// Valid/ready channels of the decoder: character input and result output.
// ----------------------------------------------------------------------------
interface nfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface nfd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic        check_ok;
  logic [31:0] byte_total;
  logic [31:0] received_check;

  modport source (output valid, output result_kind, output data_byte, output check_ok,
                  output byte_total, output received_check, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input check_ok,
                  input byte_total, input received_check, output ready);
endinterface
`default_nettype wire

[hw/rtl/nfd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_core
// Input register and decode state: nibble pairing, sum, count and trailer.
// ----------------------------------------------------------------------------
module nfd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_char,
  output logic                 in_ready,
  output logic                 res_valid,
  output nfd_pkg::result_t     res,
  input  wire logic            res_ready
);

  logic                         s1_valid_r;
  logic [nfd_pkg::CHAR_W-1:0]   s1_char_r;

  logic        in_trailer_r,    in_trailer_nxt;
  logic        half_pending_r,  half_pending_nxt;
  logic [3:0]  high_nibble_r,   high_nibble_nxt;
  logic [31:0] running_sum_r,   running_sum_nxt;
  logic [31:0] byte_counter_r,  byte_counter_nxt;
  logic [2:0]  trailer_count_r, trailer_count_nxt;
  logic [31:0] trailer_value_r, trailer_value_nxt;

  logic        advance;
  logic        gen;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [31:0] tv_shift;

  assign advance  = s1_valid_r && res_ready;
  assign in_ready = !s1_valid_r || res_ready;
  assign nib      = s1_char_r[3:0];
  assign byte_val = {high_nibble_r, nib};
  assign tv_shift = {trailer_value_r[27:0], nib};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char[nfd_pkg::CHAR_W-1:0];
    end
  end

  always_comb begin
    in_trailer_nxt     = in_trailer_r;
    half_pending_nxt   = half_pending_r;
    high_nibble_nxt    = high_nibble_r;
    running_sum_nxt    = running_sum_r;
    byte_counter_nxt   = byte_counter_r;
    trailer_count_nxt  = trailer_count_r;
    trailer_value_nxt  = trailer_value_r;
    gen                = 1'b0;
    res                = '0;
    res.kind           = nfd_pkg::KIND_DATA;

    if (in_trailer_r) begin
      trailer_value_nxt = tv_shift;
      if (trailer_count_r == nfd_pkg::TRAILER_LAST) begin
        gen                = 1'b1;
        res.kind           = nfd_pkg::KIND_STATUS;
        res.check_ok       = ((byte_counter_r + running_sum_r) == tv_shift);
        res.byte_total     = byte_counter_r;
        res.received_check = tv_shift;
        in_trailer_nxt     = 1'b0;
        half_pending_nxt   = 1'b0;
        high_nibble_nxt    = '0;
        running_sum_nxt    = '0;
        byte_counter_nxt   = '0;
        trailer_count_nxt  = '0;
        trailer_value_nxt  = '0;
      end else begin
        trailer_count_nxt = trailer_count_r + 3'd1;
      end
    end else if (s1_char_r == nfd_pkg::CH_END) begin
      in_trailer_nxt    = 1'b1;
      half_pending_nxt  = 1'b0;
      high_nibble_nxt   = '0;
      trailer_count_nxt = '0;
      trailer_value_nxt = '0;
    end else if (s1_char_r inside {[nfd_pkg::CH_LOW:nfd_pkg::CH_HIGH]}) begin
      if (!half_pending_r) begin
        high_nibble_nxt  = nib;
        half_pending_nxt = 1'b1;
      end else begin
        gen              = 1'b1;
        res.data_byte    = byte_val;
        half_pending_nxt = 1'b0;
        high_nibble_nxt  = '0;
        running_sum_nxt  = running_sum_r + {24'd0, byte_val};
        byte_counter_nxt = byte_counter_r + 32'd1;
      end
    end
  end

  assign res_valid = s1_valid_r && gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_trailer_r    <= 1'b0;
      half_pending_r  <= 1'b0;
      high_nibble_r   <= '0;
      running_sum_r   <= '0;
      byte_counter_r  <= '0;
      trailer_count_r <= '0;
      trailer_value_r <= '0;
    end else if (advance) begin
      in_trailer_r    <= in_trailer_nxt;
      half_pending_r  <= half_pending_nxt;
      high_nibble_r   <= high_nibble_nxt;
      running_sum_r   <= running_sum_nxt;
      byte_counter_r  <= byte_counter_nxt;
      trailer_count_r <= trailer_count_nxt;
      trailer_value_r <= trailer_value_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nfd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_out_reg
// Result register; takes a new result whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module nfd_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            res_valid,
  input  wire nfd_pkg::result_t res,
  output logic                 res_ready,
  output logic                 out_valid,
  output nfd_pkg::result_t     out_res,
  input  wire logic            out_ready
);

  logic             out_valid_r;
  nfd_pkg::result_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nibble_text_fork_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_text_fork_decoder_top
// Decodes character pairs into bytes and checks the fork trailer.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake          Payload
// in_chan    in   valid / ready      in_char[7:0]
// out_chan   out  valid / ready      result_kind, data_byte, check_ok,
//                                    byte_total[31:0], received_check[31:0]
//
// One item per cycle sustained while the output is ready; an accepted item passes
// the input register, then the result register, before its result is valid.
// Decode state updates as the input register hands its item to the result
// register, so a stalled output holds the whole pipe, nothing is dropped.
// Synchronous active-low reset clears all decode state to the data phase.
// ----------------------------------------------------------------------------
module nibble_text_fork_decoder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nfd_in_if.sink     in_chan,
  nfd_out_if.source  out_chan
);

  logic             res_valid;
  logic             res_ready;
  nfd_pkg::result_t res;
  nfd_pkg::result_t out_res;

  nfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_char   (in_chan.in_char),
    .in_ready  (in_chan.ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  nfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_chan.valid),
    .out_res   (out_res),
    .out_ready (out_chan.ready)
  );

  assign out_chan.result_kind    = out_res.kind;
  assign out_chan.data_byte      = out_res.data_byte;
  assign out_chan.check_ok       = out_res.check_ok;
  assign out_chan.byte_total     = out_res.byte_total;
  assign out_chan.received_check = out_res.received_check;

endmodule
`default_nettype wire
